// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 8;
    localparam int COUNT_FIELD_W    = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [VALUE_W-1:0] item_value;
    } mpq_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]       removed_value;
        logic                     removed_valid;
        logic                     refused;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } mpq_rsp_t;

    typedef struct packed {
        logic               insert_en;
        logic               remove_en;
        logic [VALUE_W-1:0] value;
    } mpq_cell_ctrl_t;

endpackage

// ===== rtl/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// One entry of the sorted chain: compare against the broadcast value and
// keep, load, or take a neighbor's entry.
// ----------------------------------------------------------------------------
module mpq_cell
    import mpq_pkg::*;
(
    input  logic               clk,
    input  mpq_cell_ctrl_t     ctrl,
    input  logic               occupied,
    input  logic [VALUE_W-1:0] left_value,
    input  logic               left_ge,
    input  logic [VALUE_W-1:0] right_value,
    output logic [VALUE_W-1:0] value,
    output logic               ge
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    assign ge    = occupied && (value_reg >= ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (ge)
            begin
                value_next = value_reg;
            end
            else if (left_ge)
            begin
                value_next = ctrl.value;
            end
            else
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.remove_en)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded multiset of 8-bit values with insert and remove-largest.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy never rises, and
// the result of a transaction accepted at one edge is on rsp with done high for
// the following cycle. Entries live in a row of cells kept in descending
// order; each transaction is one parallel compare in every cell followed by a
// one-place shift of the chain. An insert into a full queue or a removal from
// an empty one is refused and leaves the contents unchanged. The receiver
// cannot stall results.
module max_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  mpq_cmd_t cmd,
    output logic     done,
    output mpq_rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    mpq_rsp_t         rsp_reg;
    mpq_rsp_t         rsp_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             insert_ok;
    logic             remove_ok;
    mpq_cell_ctrl_t   cell_ctrl;

    logic [VALUE_W-1:0] cell_value [CAPACITY];
    logic               cell_ge    [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign insert_ok = accept && (cmd.opcode == OP_INSERT) && !is_full;
    assign remove_ok = accept && (cmd.opcode == OP_REMOVE) && !is_empty;

    assign cell_ctrl.insert_en = insert_ok;
    assign cell_ctrl.remove_en = remove_ok;
    assign cell_ctrl.value     = cmd.item_value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] left_value;
            logic               left_ge;
            logic [VALUE_W-1:0] right_value;

            if (gi == 0)
            begin : g_head
                assign left_value = '0;
                assign left_ge    = 1'b1;
            end
            else
            begin : g_body
                assign left_value = cell_value[gi-1];
                assign left_ge    = cell_ge[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_value = cell_value[gi];
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            mpq_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_value  (left_value),
                .left_ge     (left_ge),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .ge          (cell_ge[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (insert_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (remove_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_next.removed_value = remove_ok ? cell_value[0] : '0;
        rsp_next.removed_valid = remove_ok;
        rsp_next.refused       = accept && !insert_ok && !remove_ok;
        rsp_next.entry_count   = COUNT_FIELD_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction without result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.removed_valid && rsp.refused))
        else $error("removal both valid and refused");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.removed_valid) |-> (count_reg + 1'b1 == $past(count_reg)))
        else $error("removal did not drop occupancy by one");
`endif

endmodule
